// File: rtl/tcd_pkg.sv
// Shared types, constants and register indexes for the tile map cell decoder.
// No dependencies; used by tcd_cell and tilemap_cell_decoder under rtl/.
package tcd_pkg;

  localparam int unsigned MAP_PAGES_DEF     = 16;
  localparam int unsigned TILE_COUNT_DEF    = 8192;
  localparam int unsigned SCREEN_HEIGHT_DEF = 224;
  localparam int unsigned PAGE_WORDS        = 2048;
  localparam int unsigned WORD_W            = 16;
  localparam int unsigned IN_TDATA_W        = 48;
  localparam int unsigned OUT_TDATA_W       = 48;
  localparam int unsigned CFG_INDEX_W       = 3;
  localparam int unsigned CFG_DATA_W        = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAGE_SELECT   = 3'd0,
    CFG_SCROLL_X      = 3'd1,
    CFG_SCROLL_Y      = 3'd2,
    CFG_ROW_SCROLL    = 3'd3,
    CFG_COLUMN_SCROLL = 3'd4,
    CFG_BANK_SELECT   = 3'd5,
    CFG_X_CLAMP       = 3'd6,
    CFG_SCREEN_WIDTH  = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  typedef struct packed {
    logic [15:0] page_select;
    logic [15:0] scroll_x_word;
    logic [15:0] scroll_y_word;
    logic [15:0] row_scroll_word;
    logic [15:0] column_scroll_word;
    logic [7:0]  bank_select;
    logic [9:0]  x_clamp;
    logic [9:0]  screen_width;
  } tcd_cfg_t;

  localparam logic [7:0] BANK_SELECT_RST  = 8'd16;
  localparam logic [9:0] X_CLAMP_RST      = 10'd192;
  localparam logic [9:0] SCREEN_WIDTH_RST = 10'd320;

  typedef struct packed {
    logic signed [10:0] x;
    logic signed [9:0]  y;
  } tcd_pos_t;

endpackage

// File: rtl/tcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tcd_cell.sv
// Cell front end: quadrant page pick, tile map address and scrolled screen position.
// Depends on tcd_pkg.
module tcd_cell #(
  parameter int unsigned MAP_PAGES = tcd_pkg::MAP_PAGES_DEF,
  localparam int unsigned AW = $clog2(MAP_PAGES * tcd_pkg::PAGE_WORDS)
) (
  input  tcd_pkg::tcd_cfg_t cfg,
  input  logic [5:0]        cell_row,
  input  logic [6:0]        cell_col,
  output logic [AW-1:0]     rd_addr,
  output tcd_pkg::tcd_pos_t pos
);

  logic [1:0]         quad;
  logic [3:0]         page_raw;
  logic [3:0]         page;
  logic [14:0]        addr_full;
  logic [15:0]        xs;
  logic [15:0]        ys;
  logic [9:0]         xdiff;
  logic signed [11:0] x0;
  logic signed [12:0] xsum;
  logic signed [11:0] xw;
  logic signed [10:0] y0;
  logic signed [10:0] yw;

  assign quad     = {cell_row[5], cell_col[6]};
  assign page_raw = cfg.page_select[{quad, 2'b00} +: 4];

  // page modulo the store's page count (MAP_PAGES), as a constant table
  always_comb begin
    page = '0;
    for (int k = 0; k < 16; k++) begin
      if (page_raw == 4'(k)) begin
        page = 4'(k % MAP_PAGES);
      end
    end
  end

  assign addr_full = {page, cell_row[4:0], cell_col[5:0]};
  assign rd_addr   = addr_full[AW-1:0];

  assign xs = cfg.scroll_x_word[15] ? cfg.row_scroll_word : cfg.scroll_x_word;
  assign ys = cfg.scroll_y_word[15] ? cfg.column_scroll_word : cfg.scroll_y_word;

  assign xdiff = cfg.x_clamp - xs[9:0];
  assign x0    = $signed({2'b00, cell_col, 3'b000}) - $signed({2'b00, xdiff});
  assign xsum  = $signed({x0[11], x0}) + $signed({3'b000, cfg.x_clamp});
  assign xw    = xsum[12] ? (x0 + 12'sd1024) : x0;

  assign y0 = $signed({2'b00, cell_row, 3'b000}) - $signed({2'b00, ys[8:0]});
  assign yw = (y0 < -11'sd288) ? (y0 + 11'sd512) : y0;

  assign pos.x = xw[10:0];
  assign pos.y = yw[9:0];

endmodule

// File: rtl/tilemap_cell_decoder.sv
// Tile map cell decoder top level. A cell word accepted on the input passes the read
// stage (store read) and then the output register before it shows on m_tvalid.
// Throughput: one word per cycle, write or decode, back to back while m_tready is high.
// Writes land in the store at the accept edge. Reset clears the pipeline valids and sets
// the config registers to their defaults; the tile store holds unknown data until written.
// Depends on tcd_pkg, tcd_ram, tcd_cell.
module tilemap_cell_decoder #(
  parameter int unsigned MAP_PAGES     = tcd_pkg::MAP_PAGES_DEF,
  parameter int unsigned TILE_COUNT    = tcd_pkg::TILE_COUNT_DEF,
  parameter int unsigned SCREEN_HEIGHT = tcd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // word_addr[14:0], word_data[30:15], cell_row[36:31], cell_col[43:37],
  // draw_prio[44], zero fill
  input  logic [tcd_pkg::IN_TDATA_W-1:0]     s_tdata,
  // func[0]
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // visible[0], clip_needed[1], tile_code[14:2], colour[21:15], palette_bank[23:22],
  // pos_x[34:24], pos_y[44:35], zero fill
  output logic [tcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [tcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned DEPTH = MAP_PAGES * tcd_pkg::PAGE_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);

  tcd_pkg::tcd_cfg_t cfg;

  logic [14:0]       in_addr;
  logic [15:0]       in_data;
  logic [5:0]        in_row;
  logic [6:0]        in_col;
  logic              in_prio;
  logic              s_accept;
  logic              is_decode;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [15:0]       rd_data;
  tcd_pkg::tcd_pos_t cell_pos;

  logic              s1_valid;
  logic              s1_adv;
  tcd_pkg::tcd_pos_t s1_pos;
  logic              s1_prio;

  logic [3:0]         bank;
  logic [15:0]        code_full;
  logic [12:0]        code;
  logic [6:0]         colour;
  logic signed [11:0] xe;
  logic signed [11:0] ye;
  logic signed [11:0] we_s;
  logic signed [11:0] h_s;
  logic               drawn;
  logic               full;
  logic               part;
  logic               visible;
  logic               clip;

  logic                            out_valid;
  logic [tcd_pkg::OUT_TDATA_W-1:0] out_data;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_select        <= '0;
      cfg.scroll_x_word      <= '0;
      cfg.scroll_y_word      <= '0;
      cfg.row_scroll_word    <= '0;
      cfg.column_scroll_word <= '0;
      cfg.bank_select        <= tcd_pkg::BANK_SELECT_RST;
      cfg.x_clamp            <= tcd_pkg::X_CLAMP_RST;
      cfg.screen_width       <= tcd_pkg::SCREEN_WIDTH_RST;
    end else if (cfg_we) begin
      case (tcd_pkg::cfg_idx_t'(cfg_index))
        tcd_pkg::CFG_PAGE_SELECT:   cfg.page_select        <= cfg_data;
        tcd_pkg::CFG_SCROLL_X:      cfg.scroll_x_word      <= cfg_data;
        tcd_pkg::CFG_SCROLL_Y:      cfg.scroll_y_word      <= cfg_data;
        tcd_pkg::CFG_ROW_SCROLL:    cfg.row_scroll_word    <= cfg_data;
        tcd_pkg::CFG_COLUMN_SCROLL: cfg.column_scroll_word <= cfg_data;
        tcd_pkg::CFG_BANK_SELECT:   cfg.bank_select        <= cfg_data[7:0];
        tcd_pkg::CFG_X_CLAMP:       cfg.x_clamp            <= cfg_data[9:0];
        tcd_pkg::CFG_SCREEN_WIDTH:  cfg.screen_width       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign in_addr = s_tdata[14:0];
  assign in_data = s_tdata[30:15];
  assign in_row  = s_tdata[36:31];
  assign in_col  = s_tdata[43:37];
  assign in_prio = s_tdata[44];

  assign s1_adv    = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || s1_adv;
  assign s_accept  = s_tvalid && s_tready;
  assign is_decode = (tcd_pkg::func_t'(s_tuser) == tcd_pkg::FUNC_DECODE);
  assign wr_en     = s_accept && !is_decode && ({1'b0, in_addr} < 16'(DEPTH));
  assign rd_en     = s_accept && is_decode;

  tcd_cell #(
    .MAP_PAGES(MAP_PAGES)
  ) u_cell (
    .cfg     (cfg),
    .cell_row(in_row),
    .cell_col(in_col),
    .rd_addr (rd_addr),
    .pos     (cell_pos)
  );

  tcd_ram #(
    .WIDTH(tcd_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_addr[AW-1:0]),
    .wdata(in_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // read stage: tile word arrives from the store
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pos  <= cell_pos;
      s1_prio <= in_prio;
    end
  end

  assign bank      = rd_data[12] ? cfg.bank_select[7:4] : cfg.bank_select[3:0];
  assign code_full = {bank, rd_data[11:0]} & 16'(TILE_COUNT - 1);
  assign code      = code_full[12:0];
  assign colour    = rd_data[12:6];

  assign xe   = {s1_pos.x[10], s1_pos.x};
  assign ye   = {{2{s1_pos.y[9]}}, s1_pos.y};
  assign we_s = $signed({2'b00, cfg.screen_width});
  assign h_s  = $signed(12'(SCREEN_HEIGHT));

  assign drawn   = (rd_data[15] == s1_prio) && (code != '0);
  assign full    = (xe > 12'sd7) && (xe < we_s - 12'sd8) &&
                   (ye > 12'sd7) && (ye <= h_s - 12'sd8);
  assign part    = (xe > -12'sd8) && (xe < we_s) && (ye > -12'sd8) && (ye < h_s);
  assign visible = drawn && (full || part);
  assign clip    = drawn && !full && part;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= {3'b000, s1_pos.y, s1_pos.x, colour[6:5], colour, code, clip, visible};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_clip_implies_visible: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
    else $error("clip flag set on a word that is not visible");

  a_s1_follows_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (s1_valid == $past(is_decode)))
    else $error("read stage valid does not track the accepted word");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stalled read stage dropped its word");

  a_no_read_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> (!rd_en && !wr_en))
    else $error("store accessed while the read stage is stalled");

endmodule

// File: sim/tb.sv
// Self-checking testbench for tilemap_cell_decoder: directed table, then random
// map writes and cell decodes under several register settings, with stalls on both sides.
// Depends on rtl/tcd_pkg.sv and the decoder RTL; the expected cell results come from tb.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_PAGES   = tcd_pkg::MAP_PAGES_DEF;
  localparam int unsigned TILE_COUNT  = tcd_pkg::TILE_COUNT_DEF;
  localparam int unsigned SCREEN_H    = tcd_pkg::SCREEN_HEIGHT_DEF;
  localparam int unsigned STORE_WORDS = MAP_PAGES * tcd_pkg::PAGE_WORDS;
  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_ITEMS = 54;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 6;
  localparam int          LIMIT       = 200000;

  typedef struct packed {
    logic signed [9:0]  pos_y;
    logic signed [10:0] pos_x;
    logic [1:0]         palette_bank;
    logic [6:0]         colour;
    logic [12:0]        tile_code;
    logic               clip_needed;
    logic               visible;
  } cell_result_t;

  typedef struct packed {
    tcd_pkg::func_t fn;
    logic [14:0]    addr;
    logic [15:0]    data;
    logic [5:0]     row;
    logic [6:0]     col;
    logic           prio;
    logic           typed;
    cell_result_t   exp;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [tcd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [tcd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_we = 1'b0;
  logic [tcd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tcd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  tilemap_cell_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block: registers and tile map
  tcd_pkg::tcd_cfg_t shadow_cfg = '{page_select: '0, scroll_x_word: '0, scroll_y_word: '0,
                                    row_scroll_word: '0, column_scroll_word: '0,
                                    bank_select: tcd_pkg::BANK_SELECT_RST,
                                    x_clamp: tcd_pkg::X_CLAMP_RST,
                                    screen_width: tcd_pkg::SCREEN_WIDTH_RST};
  logic [15:0]  tile_mem [0:STORE_WORDS-1];
  bit           tile_written [0:STORE_WORDS-1];
  cell_result_t pending_cells[$];
  stim_row_t    directed_rows[$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycles = 0;
  int          errors = 0;
  int          cells_sent = 0;
  int          writes_sent = 0;
  int          settings_run = 1;

  function automatic int unsigned cell_addr(input logic [5:0] row, input logic [6:0] col);
    int unsigned quad, page;
    quad = 32'({row[5], col[6]});
    page = ((shadow_cfg.page_select >> (4 * quad)) & 16'hf) % MAP_PAGES;
    return page * tcd_pkg::PAGE_WORDS + 64 * row[4:0] + col[5:0];
  endfunction

  function automatic cell_result_t predict_cell(input logic [5:0] row, input logic [6:0] col,
                                                input logic prio);
    cell_result_t r;
    logic [15:0]  w;
    int unsigned  raw, bank, code, xs, ys;
    int           x, y, wd;
    bit           drawn, full, part;
    w    = tile_mem[cell_addr(row, col)];
    raw  = 32'(w[12:0]);
    bank = 32'((raw >= 32'h1000) ? shadow_cfg.bank_select[7:4]
                                 : shadow_cfg.bank_select[3:0]);
    code = (bank * 32'h1000 + (raw & 32'hfff)) & (TILE_COUNT - 1);
    xs   = 32'(shadow_cfg.scroll_x_word[15] ? shadow_cfg.row_scroll_word
                                             : shadow_cfg.scroll_x_word);
    ys   = 32'(shadow_cfg.scroll_y_word[15] ? shadow_cfg.column_scroll_word
                                             : shadow_cfg.scroll_y_word);
    x = 8 * int'(col) - int'((shadow_cfg.x_clamp - xs) & 32'h3ff);
    if (x < -int'(shadow_cfg.x_clamp)) x += 1024;
    y = 8 * int'(row) - int'(ys & 32'h1ff);
    if (y < -288) y += 512;
    wd    = int'(shadow_cfg.screen_width);
    drawn = (w[15] == prio) && (code != 0);
    full  = x > 7 && x < wd - 8 && y > 7 && y <= int'(SCREEN_H) - 8;
    part  = x > -8 && x < wd && y > -8 && y < int'(SCREEN_H);
    r.visible      = drawn && (full || part);
    r.clip_needed  = drawn && !full && part;
    r.tile_code    = code[12:0];
    r.colour       = w[12:6];
    r.palette_bank = w[12:11];
    r.pos_x        = x[10:0];
    r.pos_y        = y[9:0];
    return r;
  endfunction

  task automatic tab_write(input logic [14:0] a, input logic [15:0] d);
    stim_row_t w;
    w = '0;
    w.fn = tcd_pkg::FUNC_WRITE;
    w.addr = a;
    w.data = d;
    directed_rows.push_back(w);
  endtask

  task automatic tab_cell(input logic [5:0] r, input logic [6:0] c, input logic p);
    stim_row_t w;
    w = '0;
    w.fn = tcd_pkg::FUNC_DECODE;
    w.row = r;
    w.col = c;
    w.prio = p;
    directed_rows.push_back(w);
  endtask

  task automatic tab_cell_exp(input logic [5:0] r, input logic [6:0] c, input logic p,
                              input logic vis, input logic clip, input logic [12:0] code,
                              input logic [6:0] colour, input logic [1:0] pb,
                              input int x, input int y);
    stim_row_t w;
    w = '0;
    w.fn = tcd_pkg::FUNC_DECODE;
    w.row = r;
    w.col = c;
    w.prio = p;
    w.typed = 1'b1;
    w.exp = '{pos_y: y[9:0], pos_x: x[10:0], palette_bank: pb, colour: colour,
              tile_code: code, clip_needed: clip, visible: vis};
    directed_rows.push_back(w);
  endtask

  // offer one word, return at the edge where it is taken
  task automatic send_word(input stim_row_t w);
    if (w.fn == tcd_pkg::FUNC_WRITE) begin
      w.row  = 6'($urandom);
      w.col  = 7'($urandom);
      w.prio = 1'($urandom);
    end else begin
      w.addr = 15'($urandom);
      w.data = 16'($urandom);
    end
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.fn;
    s_tdata  <= {3'b000, w.prio, w.col, w.row, w.data, w.addr};
    do @(posedge clk); while (!s_tready);
    if (w.fn == tcd_pkg::FUNC_WRITE) begin
      if (w.addr < STORE_WORDS) begin
        tile_mem[w.addr]     = w.data;
        tile_written[w.addr] = 1'b1;
      end
      writes_sent++;
    end else begin
      pending_cells.push_back(w.typed ? w.exp : predict_cell(w.row, w.col, w.prio));
      cells_sent++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tcd_pkg::cfg_idx_t idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int ph);
    tcd_pkg::tcd_cfg_t c;
    c.page_select        = 16'($urandom);
    c.scroll_x_word      = 16'($urandom);
    c.scroll_y_word      = 16'($urandom);
    c.row_scroll_word    = 16'($urandom);
    c.column_scroll_word = 16'($urandom);
    c.bank_select        = 8'($urandom);
    c.x_clamp            = 10'($urandom);
    c.screen_width       = 10'($urandom);
    case (ph)
      0: begin
        c = '0;  // narrow screen, no scroll, bank 0
      end
      1: begin
        c = '1;
      end
      2: begin
        c.scroll_x_word[15] = 1'b1;
        c.scroll_y_word[15] = 1'b1;
        c.bank_select       = tcd_pkg::BANK_SELECT_RST;
        c.x_clamp           = tcd_pkg::X_CLAMP_RST;
        c.screen_width      = 10'd7;
      end
      3: begin
        c.scroll_x_word = 16'($urandom_range(0, 511));
        c.scroll_y_word = 16'($urandom_range(0, 511));
        c.x_clamp       = tcd_pkg::X_CLAMP_RST;
        c.screen_width  = tcd_pkg::SCREEN_WIDTH_RST;
      end
      default: ;
    endcase
    write_reg(tcd_pkg::CFG_PAGE_SELECT, c.page_select);
    write_reg(tcd_pkg::CFG_SCROLL_X, c.scroll_x_word);
    write_reg(tcd_pkg::CFG_SCROLL_Y, c.scroll_y_word);
    write_reg(tcd_pkg::CFG_ROW_SCROLL, c.row_scroll_word);
    write_reg(tcd_pkg::CFG_COLUMN_SCROLL, c.column_scroll_word);
    write_reg(tcd_pkg::CFG_BANK_SELECT, {8'h00, c.bank_select});
    write_reg(tcd_pkg::CFG_X_CLAMP, {6'h00, c.x_clamp});
    write_reg(tcd_pkg::CFG_SCREEN_WIDTH, {6'h00, c.screen_width});
    cfg_we <= 1'b0;
    shadow_cfg = c;
    settings_run++;
  endtask

  // mostly write-then-decode pairs and decodes of mapped cells, some stray writes
  task automatic random_items(input int n);
    stim_row_t w;
    int        left, pick;
    left = n;
    while (left > 0) begin
      pick   = $urandom_range(0, 99);
      w      = '0;
      w.row  = 6'($urandom);
      w.col  = 7'($urandom);
      w.prio = 1'($urandom);
      w.data = 16'($urandom);
      w.addr = 15'(cell_addr(w.row, w.col));
      if (pick < 75) begin
        if (pick < 40 || !tile_written[w.addr]) begin
          w.fn = tcd_pkg::FUNC_WRITE;
          send_word(w);
          left--;
        end
        w.fn = tcd_pkg::FUNC_DECODE;
        send_word(w);
      end else begin
        w.fn   = tcd_pkg::FUNC_WRITE;
        w.addr = 15'($urandom);
        send_word(w);
      end
      left--;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cell_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[44:0];
      if (pending_cells.size() == 0) begin
        if (errors < 10)
          $display("cycle %0d: cell result %h with none expected", cycles, got);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        if (got !== want) begin
          if (errors < 10) begin
            $write("cycle %0d got/want: vis %0d/%0d clip %0d/%0d code %h/%h ", cycles,
                   got.visible, want.visible, got.clip_needed, want.clip_needed,
                   got.tile_code, want.tile_code);
            $display("colour %h/%h bank %0d/%0d x %0d/%0d y %0d/%0d",
                     got.colour, want.colour, got.palette_bank, want.palette_bank,
                     got.pos_x, want.pos_x, got.pos_y, want.pos_y);
          end
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d cell results outstanding",
               cycles, pending_cells.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int ph;
    // reset settings: bank 0x10, clamp 192, width 320, no scroll, page 0
    tab_write(15'd0, 16'h0000);
    tab_cell_exp(6'd0, 7'd0, 1'b0, 1'b0, 1'b0, 13'h0000, 7'h00, 2'd0, -192, 0);
    tab_write(15'd1, 16'hffff);
    tab_cell_exp(6'd0, 7'd1, 1'b1, 1'b0, 1'b0, 13'h1fff, 7'h7f, 2'd3, -184, 0);
    tab_cell_exp(6'd0, 7'd1, 1'b0, 1'b0, 1'b0, 13'h1fff, 7'h7f, 2'd3, -184, 0);
    tab_write(15'd89, 16'h0001);
    tab_cell_exp(6'd1, 7'd25, 1'b0, 1'b1, 1'b0, 13'h0001, 7'h00, 2'd0, 8, 8);
    tab_cell_exp(6'd1, 7'd25, 1'b1, 1'b0, 1'b0, 13'h0001, 7'h00, 2'd0, 8, 8);
    tab_write(15'd88, 16'h8002);
    tab_cell_exp(6'd1, 7'd24, 1'b1, 1'b1, 1'b1, 13'h0002, 7'h00, 2'd0, 0, 8);
    tab_write(15'd1753, 16'h0003);
    tab_cell_exp(6'd27, 7'd25, 1'b0, 1'b1, 1'b0, 13'h0003, 7'h00, 2'd0, 8, 216);
    tab_write(15'h7fff, 16'ha5a5);
    tab_write(15'd2047, 16'h7fc0);
    tab_cell_exp(6'd63, 7'd127, 1'b0, 1'b0, 1'b0, 13'h1fc0, 7'h7f, 2'd3, 824, 504);
    tab_cell(6'd63, 7'd127, 1'b1);
    tab_write(15'd64, 16'h1234);
    tab_cell(6'd33, 7'd64, 1'b0);
    tab_cell(6'd32, 7'd0, 1'b1);
    tab_cell(6'd0, 7'd64, 1'b0);
    tab_write(15'd90, 16'h9fff);
    tab_cell(6'd1, 7'd26, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) send_word(directed_rows[i]);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      apply_setting(ph);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin src_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      if (ph == 4) hold_req++;  // long output hold-off while the sender keeps offering
      random_items(PHASE_ITEMS / 2);
      drain();
      random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
      drain();
    end

    errors += pending_cells.size();
    $display("ran %0d cell decodes and %0d map writes over %0d register settings",
             cells_sent, writes_sent, settings_run);
    $display("idle and stall mixes plus a %0d-cycle output hold-off, %0d cycles, %0d errors",
             HOLD_CYCLES, cycles, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
